// ----- rtl/core/evpd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// evpd_pkg
// Shared types, register map and constants of the encoder velocity PD
// duty controller.
// ---------------------------------------------------------------------------
package evpd_pkg;

  localparam int AVG_DEPTH_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int SPEED_W  = 30;
  localparam int DUTY_W   = 17;
  localparam int TGT_W    = 31;
  localparam int GAIN_W   = 32;
  localparam int RATE_W   = 24;
  localparam int WCOUNT_W = 16;
  localparam int ERR_W    = 32;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // quotient bits retired per cycle by the mean divider
  localparam int DIV_STEP = 6;

  localparam logic [DUTY_W-1:0]  DUTY_FULL = 17'h10000;
  localparam logic [DUTY_W-1:0]  DUTY_HALF = 17'h08000;
  localparam logic [SPEED_W-1:0] SPEED_CAP = 30'd655360000;
  localparam logic [RATE_W-1:0]  RATE_RST  = 24'd65536;

  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;
  localparam logic       MODE_OPEN = 1'b1;

  localparam logic FUNC_TICK = 1'b1;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_KP     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_DIR    = 3'd4;
  localparam logic [2:0] REG_ODUTY  = 3'd5;
  localparam logic [2:0] REG_RATE   = 3'd6;

  typedef struct packed {
    logic signed [TGT_W-1:0]  target_speed;
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic                     loop_mode;
    logic [1:0]               drive_dir;
    logic [DUTY_W-1:0]        open_duty;
  } evpd_cfg_t;

endpackage

// ----- rtl/core/encoder_velocity_pd_duty_control.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_velocity_pd_duty_control
// Encoder transition counter, windowed speed average and PD duty update.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  in       | in_valid / in_ready    | func, enc_a, enc_b
//  out      | out_valid / out_ready  | duty_level, speed_avg, window_count
//  apb      | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
//  An encoder sample yields no beat. A tick passes through the history RAM
//  read-modify-write and the iterative divide of the running sum. No new
//  item is taken during a tick; a result waiting on out_ready stalls only
//  the next tick's final load. Reset is synchronous; the history RAM needs
//  no clearing pass, per-entry valid bits mask unwritten entries.
// ---------------------------------------------------------------------------
module encoder_velocity_pd_duty_control #(
  parameter int AVG_DEPTH  = evpd_pkg::AVG_DEPTH_DEF,
  parameter int COUNT_BITS = evpd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [evpd_pkg::ADDR_W-1:0]   paddr,
  input  logic [evpd_pkg::DATA_W-1:0]   pwdata,
  output logic [evpd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic                          enc_a,
  input  logic                          enc_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [evpd_pkg::DUTY_W-1:0]   duty_level,
  output logic [evpd_pkg::SPEED_W-1:0]  speed_avg,
  output logic [evpd_pkg::WCOUNT_W-1:0] window_count
);
  import evpd_pkg::*;

  localparam int PROD_W = COUNT_BITS + RATE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPD   = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_PWAIT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  evpd_cfg_t         cfg;
  logic [RATE_W-1:0] rate_scale;

  logic [2:0]            state;
  logic [1:0]            prev_pair;
  logic [COUNT_BITS-1:0] trans_count;
  logic [COUNT_BITS-1:0] count_lat;
  logic [PROD_W-1:0]     speed_prod;

  logic                  wr_en;
  logic [2:0]            reg_idx;
  logic                  in_fire;
  logic [1:0]            pair;
  logic [SPEED_W-1:0]    speed_sat;
  logic [31:0]           cnt_wide;
  logic [WCOUNT_W-1:0]   wcount;
  logic                  mean_start;
  logic                  mean_done;
  logic [SPEED_W-1:0]    mean;
  logic                  pd_start;
  logic                  pd_done;
  logic [DUTY_W-1:0]     duty;
  logic                  out_free;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed <= '0;
      cfg.gain_prop    <= '0;
      cfg.gain_deriv   <= '0;
      cfg.loop_mode    <= 1'b0;
      cfg.drive_dir    <= '0;
      cfg.open_duty    <= DUTY_HALF;
      rate_scale       <= RATE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET: cfg.target_speed <= pwdata[TGT_W-1:0];
        REG_KP:     cfg.gain_prop    <= pwdata;
        REG_KD:     cfg.gain_deriv   <= pwdata;
        REG_MODE:   cfg.loop_mode    <= pwdata[0];
        REG_DIR:    cfg.drive_dir    <= pwdata[1:0];
        REG_ODUTY:  cfg.open_duty    <= pwdata[DUTY_W-1:0];
        REG_RATE:   rate_scale       <= pwdata[RATE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET: prdata = DATA_W'(cfg.target_speed);
      REG_KP:     prdata = cfg.gain_prop;
      REG_KD:     prdata = cfg.gain_deriv;
      REG_MODE:   prdata = DATA_W'(cfg.loop_mode);
      REG_DIR:    prdata = DATA_W'(cfg.drive_dir);
      REG_ODUTY:  prdata = DATA_W'(cfg.open_duty);
      REG_RATE:   prdata = DATA_W'(rate_scale);
      default:    prdata = '0;
    endcase
  end

  // input side and encoder counter
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pair     = {enc_b, enc_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pair   <= '0;
      trans_count <= '0;
    end else if (in_fire) begin
      if (func == FUNC_TICK) begin
        trans_count <= '0;
      end else begin
        if (pair != prev_pair && trans_count != '1) begin
          trans_count <= trans_count + 1'b1;
        end
        prev_pair <= pair;
      end
    end
  end

  // latch the closed window and its raw speed
  always_ff @(posedge clk) begin
    if (in_fire && func == FUNC_TICK) begin
      count_lat  <= trans_count;
      speed_prod <= PROD_W'(trans_count) * PROD_W'(rate_scale);
    end
  end

  assign speed_sat = (speed_prod[PROD_W-1:SPEED_W] != '0) ? '1 : speed_prod[SPEED_W-1:0];
  assign cnt_wide  = 32'(count_lat);
  assign wcount    = (cnt_wide > 32'd65535) ? '1 : cnt_wide[WCOUNT_W-1:0];

  assign mean_start = (state == S_SPD);
  assign pd_start   = (state == S_MWAIT) && mean_done;
  assign out_free   = !out_valid || out_ready;

  evpd_mean #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_mean (
    .clk  (clk),
    .rst  (rst),
    .start(mean_start),
    .speed(speed_sat),
    .done (mean_done),
    .mean (mean)
  );

  evpd_pd u_pd (
    .clk   (clk),
    .rst   (rst),
    .start (pd_start),
    .cfg   (cfg),
    .dir_wr(wr_en && reg_idx == REG_DIR),
    .mean  (mean),
    .done  (pd_done),
    .duty  (duty)
  );

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_fire && func == FUNC_TICK) state <= S_SPD;
        S_SPD:   state <= S_MWAIT;
        S_MWAIT: if (mean_done) state <= S_PWAIT;
        S_PWAIT: if (pd_done) state <= S_OUT;
        S_OUT:   if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      duty_level   <= duty;
      speed_avg    <= mean;
      window_count <= wcount;
    end
  end

  a_tick_clears_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func == FUNC_TICK) |=> (trans_count == '0))
    else $error("window count not cleared by tick");

  a_mean_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mean_done |-> (state == S_MWAIT))
    else $error("mean result outside its wait state");

  a_pd_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    pd_done |-> (state == S_PWAIT))
    else $error("duty result outside its wait state");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_free) |=> (state == S_OUT && out_valid))
    else $error("result dropped while output slot busy");

endmodule

// ----- rtl/core/evpd_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// evpd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module evpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/evpd_mean.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// evpd_mean
// Speed history in RAM with a running sum, then an iterative divide by the
// history depth and a clamp to the speed ceiling.
// ---------------------------------------------------------------------------
module evpd_mean #(
  parameter int AVG_DEPTH = evpd_pkg::AVG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [evpd_pkg::SPEED_W-1:0] speed,
  output logic                         done,
  output logic [evpd_pkg::SPEED_W-1:0] mean
);
  import evpd_pkg::*;

  localparam int PTR_W  = $clog2(AVG_DEPTH);
  localparam int SUM_W  = SPEED_W + PTR_W;
  localparam int ITERS  = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W  = ITERS * DIV_STEP;
  localparam int REM_W  = PTR_W;
  localparam int ITER_W = $clog2(ITERS);
  localparam logic [REM_W:0]    DIVISOR = (REM_W + 1)'(AVG_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(AVG_DEPTH - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERS - 1);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RD   = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;

  logic [1:0]           state;
  logic [PTR_W-1:0]     ptr;
  logic [AVG_DEPTH-1:0] vld;
  logic [SUM_W-1:0]     sum;
  logic [SPEED_W-1:0]   speed_l;
  logic [PAD_W-1:0]     dv;
  logic [PAD_W-1:0]     quo;
  logic [REM_W-1:0]     rem;
  logic [ITER_W-1:0]    iter;

  logic                 ram_re;
  logic                 ram_we;
  logic [SPEED_W-1:0]   ram_rdata;
  logic [SPEED_W-1:0]   old_speed;
  logic [SUM_W-1:0]     sum_next;
  logic [PAD_W-1:0]     dv_next;
  logic [PAD_W-1:0]     quo_next;
  logic [REM_W-1:0]     rem_next;

  assign ram_re = (state == M_IDLE) && start;
  assign ram_we = (state == M_RD);

  evpd_ram #(
    .WIDTH(SPEED_W),
    .DEPTH(AVG_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr),
    .wdata(speed_l),
    .re   (ram_re),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  // never-written entries count as zero
  assign old_speed = vld[ptr] ? ram_rdata : '0;
  assign sum_next  = sum - SUM_W'(old_speed) + SUM_W'(speed_l);

  // restoring divide by a constant, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [PAD_W-1:0] d;
    logic [PAD_W-1:0] q;
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    d = dv;
    q = quo;
    r = rem;
    t = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {r, d[PAD_W-1]};
      d = {d[PAD_W-2:0], 1'b0};
      if (t >= DIVISOR) begin
        t = t - DIVISOR;
        q = {q[PAD_W-2:0], 1'b1};
      end else begin
        q = {q[PAD_W-2:0], 1'b0};
      end
      r = t[REM_W-1:0];
    end
    dv_next  = d;
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      ptr   <= '0;
      vld   <= '0;
      sum   <= '0;
      done  <= 1'b0;
      mean  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            speed_l <= speed;
            state   <= M_RD;
          end
        end
        M_RD: begin
          sum      <= sum_next;
          vld[ptr] <= 1'b1;
          ptr      <= (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
          dv       <= PAD_W'(sum_next);
          quo      <= '0;
          rem      <= '0;
          iter     <= '0;
          state    <= M_DIV;
        end
        M_DIV: begin
          dv   <= dv_next;
          quo  <= quo_next;
          rem  <= rem_next;
          iter <= iter + 1'b1;
          if (iter == ITER_LAST) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          mean  <= (quo > PAD_W'(SPEED_CAP)) ? SPEED_CAP : quo[SPEED_W-1:0];
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/evpd_pd.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// evpd_pd
// Duty update: incremental PD in closed loop, fixed duty in open loop,
// hold in brake. One shared multiplier serves both terms.
// ---------------------------------------------------------------------------
module evpd_pd (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  evpd_pkg::evpd_cfg_t          cfg,
  input  logic                         dir_wr,
  input  logic [evpd_pkg::SPEED_W-1:0] mean,
  output logic                         done,
  output logic [evpd_pkg::DUTY_W-1:0]  duty
);
  import evpd_pkg::*;

  localparam int PROD_W = GAIN_W + ERR_W + 1;
  localparam int ND_W   = PROD_W - 14;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MP   = 2'd1;
  localparam logic [1:0] P_MD   = 2'd2;
  localparam logic [1:0] P_SUM  = 2'd3;

  logic [1:0]               state;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [ERR_W:0]    derr_r;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_d;

  logic                     drive_on;
  logic signed [ERR_W-1:0]  err_next;
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [ERR_W:0]    mul_b;
  logic signed [PROD_W-1:0] mul_y;
  logic signed [ND_W-1:0]   nd;
  logic [DUTY_W-1:0]        duty_clamp;
  logic [DUTY_W-1:0]        open_clamp;

  assign drive_on = (cfg.drive_dir == DIR_FWD) || (cfg.drive_dir == DIR_REV);
  assign err_next = ERR_W'(cfg.target_speed) - $signed({2'b00, mean});

  assign mul_a = (state == P_MP) ? cfg.gain_prop : cfg.gain_deriv;
  assign mul_b = (state == P_MP) ? (ERR_W + 1)'(err_r) : derr_r;
  assign mul_y = mul_a * mul_b;

  // floor shift of each term, then add to the held duty
  assign nd = $signed({{(ND_W - DUTY_W){1'b0}}, duty})
            + ND_W'(prod_p >>> 16) + ND_W'(prod_d >>> 16);

  always_comb begin
    if (nd < 0) begin
      duty_clamp = '0;
    end else if (nd > $signed(ND_W'(DUTY_FULL))) begin
      duty_clamp = DUTY_FULL;
    end else begin
      duty_clamp = nd[DUTY_W-1:0];
    end
  end

  assign open_clamp = (cfg.open_duty > DUTY_FULL) ? DUTY_FULL : cfg.open_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= P_IDLE;
      done     <= 1'b0;
      duty     <= DUTY_HALF;
      last_err <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (dir_wr) begin
            duty <= DUTY_HALF;
          end else if (start) begin
            if (!drive_on) begin
              done <= 1'b1;
            end else if (cfg.loop_mode == MODE_OPEN) begin
              duty <= open_clamp;
              done <= 1'b1;
            end else begin
              err_r <= err_next;
              state <= P_MP;
            end
          end
        end
        P_MP: begin
          prod_p <= mul_y;
          derr_r <= (ERR_W + 1)'(err_r) - (ERR_W + 1)'(last_err);
          state  <= P_MD;
        end
        P_MD: begin
          prod_d <= mul_y;
          state  <= P_SUM;
        end
        P_SUM: begin
          duty     <= duty_clamp;
          last_err <= err_r;
          done     <= 1'b1;
          state    <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/tb_encoder_velocity_pd_duty_control.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_encoder_velocity_pd_duty_control
// Self-checking bench for the encoder velocity PD duty controller. Encoder
// samples and control ticks go in over a valid/ready channel. Registers are
// programmed over APB while the block is quiet. A bit-true software copy of
// the counter, the speed history and the PD duty update predicts every tick
// result. A monitor compares each output beat field by field. The stimulus
// is a short directed table, then a counter saturation sweep, then random
// quadrature windows under several register settings and stall patterns.
// ---------------------------------------------------------------------------
module tb_encoder_velocity_pd_duty_control;
  import evpd_pkg::*;

  localparam logic       FUNC_SAMPLE    = 1'b0;
  localparam logic       MODE_CLOSED    = 1'b0;
  localparam logic [1:0] DIR_BRAKE      = 2'd0;
  localparam logic [1:0] DIR_BRAKE_ALT  = 2'd3;
  localparam logic [2:0] REG_SPARE      = 3'd7;
  localparam int         SETTLE_CYC     = 40;
  localparam int         REPORT_LIMIT   = 40;
  localparam longint unsigned SPEED_HIST_MAX = 64'd1073741823;
  localparam logic [COUNT_BITS_DEF-1:0] WIN_COUNT_MAX = '1;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [SPEED_W-1:0]  speed;
    logic [WCOUNT_W-1:0] wcount;
  } tick_out_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] val;
    logic        f;
    logic        a;
    logic        b;
    logic        typed;
    tick_out_t   want;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic                enc_a;
  logic                enc_b;
  logic                out_valid;
  logic                out_ready;
  logic [DUTY_W-1:0]   duty_level;
  logic [SPEED_W-1:0]  speed_avg;
  logic [WCOUNT_W-1:0] window_count;

  // typed expectation travels with the beat it belongs to
  logic      typed_on;
  tick_out_t typed_res;

  tick_out_t tick_results[$];
  tick_out_t tick_due;
  tick_out_t tick_calc;
  bit        tick_made;
  plan_row_t plan[$];

  int mismatches = 0;
  int send_idle  = 9;
  int recv_idle  = 54;
  int hold_req   = 0;
  int hold_left  = 0;

  // controller settings as programmed
  longint              cfg_target    = 0;
  longint              cfg_kp        = 0;
  longint              cfg_kd        = 0;
  logic                cfg_mode      = MODE_CLOSED;
  logic [1:0]          cfg_dir       = DIR_BRAKE;
  logic [DUTY_W-1:0]   cfg_open_duty = DUTY_HALF;
  logic [RATE_W-1:0]   cfg_rate      = RATE_RST;

  // controller state
  logic [1:0]                prev_pair  = 2'd0;
  logic [COUNT_BITS_DEF-1:0] win_count  = '0;
  logic [SPEED_W-1:0]        speed_ring [AVG_DEPTH_DEF] = '{default: '0};
  int                        ring_ptr   = 0;
  logic [SPEED_W-1:0]        mean_now   = '0;
  longint                    err_prev   = 0;
  logic [DUTY_W-1:0]         duty_now   = DUTY_HALF;

  encoder_velocity_pd_duty_control i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .enc_a        (enc_a),
    .enc_b        (enc_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .duty_level   (duty_level),
    .speed_avg    (speed_avg),
    .window_count (window_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Count transitions on samples; on a tick close the window, update the
  // speed history and mean, and run the duty update.
  task automatic track_encoder_item(input logic f, input logic a, input logic b,
                                    output bit got, output tick_out_t r);
    logic [1:0]        pair;
    longint unsigned   cnt;
    longint unsigned   spd;
    longint unsigned   sum;
    longint            err;
    longint            p_term;
    longint            d_term;
    longint            nd;
    got = 1'b0;
    r = '0;
    if (f != FUNC_TICK) begin
      pair = {b, a};
      if (pair != prev_pair && win_count < WIN_COUNT_MAX) win_count++;
      prev_pair = pair;
    end else begin
      cnt = win_count;
      win_count = '0;
      spd = cnt * cfg_rate;
      if (spd > SPEED_HIST_MAX) spd = SPEED_HIST_MAX;
      speed_ring[ring_ptr] = spd[SPEED_W-1:0];
      ring_ptr = (ring_ptr + 1) % AVG_DEPTH_DEF;
      sum = 0;
      foreach (speed_ring[i]) sum += speed_ring[i];
      sum = sum / AVG_DEPTH_DEF;
      if (sum > SPEED_CAP) sum = SPEED_CAP;
      mean_now = sum[SPEED_W-1:0];
      if (cfg_dir == DIR_FWD || cfg_dir == DIR_REV) begin
        if (cfg_mode != MODE_OPEN) begin
          err = cfg_target - longint'(mean_now);
          // arithmetic shift floors toward minus infinity
          p_term = (cfg_kp * err) >>> 16;
          d_term = (cfg_kd * (err - err_prev)) >>> 16;
          nd = longint'(duty_now) + p_term + d_term;
          err_prev = err;
          if (nd < 0) nd = 0;
          if (nd > longint'(DUTY_FULL)) nd = longint'(DUTY_FULL);
          duty_now = nd[DUTY_W-1:0];
        end else begin
          duty_now = (cfg_open_duty > DUTY_FULL) ? DUTY_FULL : cfg_open_duty;
        end
      end
      r.duty   = duty_now;
      r.speed  = mean_now;
      r.wcount = (cnt > 65535) ? 16'hFFFF : cnt[WCOUNT_W-1:0];
      got = 1'b1;
    end
  endtask

  // Check output beats against the oldest expectation, then predict from
  // the input beat taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (tick_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat duty %0d speed %0d count %0d",
                                  duty_level, speed_avg, window_count));
        end else begin
          tick_due = tick_results.pop_front();
          if (duty_level !== tick_due.duty)
            flag_mismatch($sformatf("duty_level got %0d want %0d",
                                    duty_level, tick_due.duty));
          if (speed_avg !== tick_due.speed)
            flag_mismatch($sformatf("speed_avg got %0d want %0d",
                                    speed_avg, tick_due.speed));
          if (window_count !== tick_due.wcount)
            flag_mismatch($sformatf("window_count got %0d want %0d",
                                    window_count, tick_due.wcount));
        end
      end
      if (in_valid && in_ready) begin
        track_encoder_item(func, enc_a, enc_b, tick_made, tick_calc);
        if (tick_made) tick_results.push_back(typed_on ? typed_res : tick_calc);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(input logic f, input logic a, input logic b,
                           input logic typed, input tick_out_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    enc_a     <= a;
    enc_b     <= b;
    typed_on  <= typed;
    typed_res <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for all results, then let a tick in flight finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tick_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic signed [TGT_W-1:0]  tgt;
    logic signed [GAIN_W-1:0] gain;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TARGET: begin
        tgt = val[TGT_W-1:0];
        cfg_target = tgt;
      end
      REG_KP: begin
        gain = val;
        cfg_kp = gain;
      end
      REG_KD: begin
        gain = val;
        cfg_kd = gain;
      end
      REG_MODE:  cfg_mode = val[0];
      REG_DIR: begin
        cfg_dir = val[1:0];
        duty_now = DUTY_HALF;
      end
      REG_ODUTY: cfg_open_duty = val[DUTY_W-1:0];
      REG_RATE:  cfg_rate = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic tick_out_t tick_out(input logic [DUTY_W-1:0] d,
                                         input logic [SPEED_W-1:0] s,
                                         input logic [WCOUNT_W-1:0] c);
    tick_out_t t;
    t.duty = d;
    t.speed = s;
    t.wcount = c;
    return t;
  endfunction

  function automatic void add_beat(input logic f, input logic a, input logic b,
                                   input logic typed, input tick_out_t want);
    plan_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.f = f;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  function automatic void add_write(input logic [2:0] idx, input logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endfunction

  initial begin
    int          budget;
    int          sent;
    int          len;
    int          qpos;
    int          sel;
    bit          fwd;
    bit          paused;
    logic [1:0]  g;
    logic [31:0] v;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    func      <= FUNC_SAMPLE;
    enc_a     <= 1'b0;
    enc_b     <= 1'b0;
    typed_on  <= 1'b0;
    typed_res <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty window straight after reset
    add_beat(FUNC_TICK, 1'b0, 1'b0, 1'b1, tick_out(DUTY_HALF, 30'd0, 16'd0));
    // same pair as after reset: no transition
    add_beat(FUNC_SAMPLE, 1'b0, 1'b0, 1'b0, '0);
    add_beat(FUNC_SAMPLE, 1'b1, 1'b0, 1'b0, '0);
    add_beat(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, '0);
    add_beat(FUNC_SAMPLE, 1'b0, 1'b1, 1'b0, '0);
    add_beat(FUNC_SAMPLE, 1'b0, 1'b0, 1'b0, '0);
    add_beat(FUNC_TICK, 1'b1, 1'b1, 1'b1, tick_out(DUTY_HALF, 30'd32768, 16'd4));
    // open loop, duty above full is clipped
    add_write(REG_MODE, {31'd0, MODE_OPEN});
    add_write(REG_ODUTY, 32'd100000);
    add_write(REG_DIR, {30'd0, DIR_FWD});
    add_beat(FUNC_TICK, 1'b0, 1'b0, 1'b1, tick_out(DUTY_FULL, 30'd32768, 16'd0));
    add_write(REG_ODUTY, 32'd0);
    add_beat(FUNC_TICK, 1'b0, 1'b0, 1'b1, tick_out(17'd0, 30'd32768, 16'd0));
    // closed loop with extreme gains and targets
    add_write(REG_MODE, {31'd0, MODE_CLOSED});
    add_write(REG_KP, 32'h7FFF_FFFF);
    add_write(REG_KD, 32'h8000_0000);
    add_write(REG_TARGET, 32'h3FFF_FFFF);
    add_write(REG_RATE, 32'h00FF_FFFF);
    add_write(REG_DIR, {30'd0, DIR_REV});
    add_beat(FUNC_SAMPLE, 1'b0, 1'b1, 1'b0, '0);
    add_beat(FUNC_SAMPLE, 1'b1, 1'b1, 1'b0, '0);
    add_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
    add_write(REG_TARGET, 32'hC000_0000);
    add_beat(FUNC_TICK, 1'b1, 1'b0, 1'b0, '0);
    // direction code three brakes and keeps the error memory
    add_write(REG_DIR, {30'd0, DIR_BRAKE_ALT});
    add_beat(FUNC_TICK, 1'b0, 1'b1, 1'b0, '0);
    // write to an unmapped register is dropped
    add_write(REG_SPARE, 32'hFFFF_FFFF);
    add_write(REG_DIR, {30'd0, DIR_FWD});
    add_beat(FUNC_SAMPLE, 1'b1, 1'b0, 1'b0, '0);
    add_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
    add_write(REG_RATE, 32'd0);
    add_beat(FUNC_SAMPLE, 1'b0, 1'b0, 1'b0, '0);
    add_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle_block();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send_beat(plan[i].f, plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // saturate the transition counter; the window speed hits its cap too
    settle_block();
    cfg_write(REG_RATE, 32'd65536);
    send_idle = 0;
    recv_idle = 0;
    for (int k = 0; k < 65540; k++) send_beat(FUNC_SAMPLE, ~k[0], 1'b0, 1'b0, '0);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);

    qpos = 0;
    fwd = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      settle_block();
      sel = $urandom_range(4);
      case (sel)
        0:       v = 32'h3FFF_FFFF;
        1:       v = 32'hC000_0000;
        2:       v = $urandom;
        default: v = $urandom_range(6553600) - 3276800;
      endcase
      cfg_write(REG_TARGET, v);
      v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1024) - 512;
      cfg_write(REG_KP, v);
      v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1024) - 512;
      cfg_write(REG_KD, v);
      cfg_write(REG_MODE, $urandom);
      if (ph == 0 || $urandom_range(1) == 1) cfg_write(REG_DIR, $urandom_range(3));
      cfg_write(REG_ODUTY, $urandom_range(131071));
      sel = $urandom_range(3);
      if (ph == 4 || sel == 0) v = 32'h00FF_FFFF;
      else if (sel == 1) v = $urandom;
      else v = $urandom_range(131072);
      cfg_write(REG_RATE, v);
      if ($urandom_range(3) == 0) cfg_write(REG_SPARE, $urandom);

      if (ph < 2) begin
        send_idle = 9;
        recv_idle = 54;
      end else if (ph < 4) begin
        send_idle = 54;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // long fast windows drive the mean into its cap
      budget = (ph == 4) ? 360 : 80;
      // hold the result side so the block backs up into its input
      if (ph == 1) hold_req = 300;
      sent = 0;
      paused = 1'b0;
      while (sent < budget) begin
        if (ph == 3 && !paused && sent >= budget / 2) begin
          settle_block();
          paused = 1'b1;
        end
        if (ph == 4) begin
          len = $urandom_range(64, 72);
        end else begin
          sel = $urandom_range(99);
          if (sel < 75) len = $urandom_range(8);
          else if (sel < 95) len = $urandom_range(9, 30);
          else len = $urandom_range(31, 100);
        end
        if ($urandom_range(99) < 20) fwd = ~fwd;
        for (int j = 0; j < len; j++) begin
          sel = $urandom_range(99);
          if (sel < 80) qpos = fwd ? (qpos + 1) % 4 : (qpos + 3) % 4;
          else if (sel >= 90) qpos = $urandom_range(3);
          g = qpos[1:0] ^ {1'b0, qpos[1]};
          send_beat(FUNC_SAMPLE, g[0], g[1], 1'b0, '0);
        end
        send_beat(FUNC_TICK, $urandom, $urandom, 1'b0, '0);
        sent += len + 1;
      end
    end

    settle_block();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
